>>> sv/circular_ordered_item_list_unit_assert.svh
// Assertion macros for the ordered item list unit.
`ifndef CIRCULAR_ORDERED_ITEM_LIST_UNIT_ASSERT_SVH
`define CIRCULAR_ORDERED_ITEM_LIST_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define COIL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define COIL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define COIL_ASSERT(lbl, clk, rst_n, prop, msg)
`define COIL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> sv/coil_pkg.sv
package coil_pkg;

  localparam int MODE_BITS   = 2;
  localparam int STATUS_BITS = 2;
  localparam int FRONT_BITS  = 8;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_INS_FRONT = 2'd0,
    MODE_INS_BACK  = 2'd1,
    MODE_REMOVE    = 2'd2,
    MODE_ROTATE    = 2'd3
  } mode_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOMATCH = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  // result handed from the sequencer to the output register
  typedef struct packed {
    logic                  valid;
    status_e               status;
    logic                  is_empty;
    logic [FRONT_BITS-1:0] front_item;
  } rsp_t;

endpackage

>>> sv/circular_ordered_item_list_unit.sv
// Steps: input accepted in idle, executed, then the front entry is read and the result registered;
//   a rotate adds a copy-to-back write, a remove adds search and gap closing (one RAM word a cycle).
// One word at a time: the next input is taken the cycle after the result is registered,
//   so a result-side stall or a removal walk holds off the next input.
// Reset (async, rst_ni low): list empty, front index 0, output word invalid; RAM not cleared.
`include "circular_ordered_item_list_unit_assert.svh"

module circular_ordered_item_list_unit
  import coil_pkg::*;
#(
  parameter int DEPTH     = 16,
  parameter int ITEM_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // mode[1:0], item[ITEM_BITS+1:2], zero pad to bytes
  input  logic [((MODE_BITS+ITEM_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // status[1:0], count[CW+1:2], front_item[CW+9:CW+2], is_empty[CW+10], zero pad
  output logic [((STATUS_BITS+$clog2(DEPTH+1)+FRONT_BITS+1+7)/8)*8-1:0] m_axis_tdata
);

  localparam int IW       = $clog2(DEPTH);
  localparam int CW       = $clog2(DEPTH + 1);
  localparam int OUT_BITS = STATUS_BITS + CW + FRONT_BITS + 1;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  rsp_t                 rsp;
  logic [CW-1:0]        rsp_count;
  logic                 rsp_ready;

  logic                 ram_we;
  logic [IW-1:0]        ram_waddr;
  logic [ITEM_BITS-1:0] ram_wdata;
  logic [IW-1:0]        ram_raddr;
  logic [ITEM_BITS-1:0] ram_rdata;

  // output register: the result word waits here while the next input is taken
  logic                  out_vld_q;
  status_e               out_status_q;
  logic [CW-1:0]         out_count_q;
  logic [FRONT_BITS-1:0] out_front_q;
  logic                  out_empty_q;

  // sequencer: read-modify-write of the entry RAM, search and gap closing
  coil_ctrl #(
    .DEPTH    (DEPTH),
    .ITEM_BITS(ITEM_BITS),
    .IW       (IW),
    .CW       (CW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_mode_i  (mode_e'(s_axis_tdata[MODE_BITS-1:0])),
    .in_item_i  (s_axis_tdata[MODE_BITS +: ITEM_BITS]),
    .rsp_o      (rsp),
    .rsp_count_o(rsp_count),
    .rsp_ready_i(rsp_ready),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .ram_raddr_o(ram_raddr),
    .ram_rdata_i(ram_rdata)
  );

  // entry storage, one registered read port and one write port
  coil_ram #(
    .WIDTH(ITEM_BITS),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // free when empty or when the held word leaves this cycle
  assign rsp_ready = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (rsp_ready) begin
      out_vld_q <= rsp.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp.valid && rsp_ready) begin
      out_status_q <= rsp.status;
      out_count_q  <= rsp_count;
      out_front_q  <= rsp.front_item;
      out_empty_q  <= rsp.is_empty;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_W'({out_empty_q, out_front_q, out_count_q, out_status_q});

  `COIL_ASSERT(a_count_bound, clk_i, rst_ni,
    m_axis_tvalid |-> out_count_q <= CW'(DEPTH), "count above depth")
  `COIL_ASSERT(a_empty_flag, clk_i, rst_ni,
    m_axis_tvalid |-> (out_empty_q == (out_count_q == '0)), "empty flag disagrees with count")
  `COIL_ASSERT(a_full_drop, clk_i, rst_ni,
    m_axis_tvalid && out_status_q == ST_FULL |-> out_count_q == CW'(DEPTH),
    "item dropped while not full")
  `COIL_ASSERT(a_empty_front, clk_i, rst_ni,
    m_axis_tvalid && out_empty_q |-> out_front_q == '0, "front item nonzero on empty list")
  `COIL_ASSERT_ALWAYS(a_rst_quiet, clk_i,
    !rst_ni |-> !m_axis_tvalid, "output word valid in reset")

endmodule

>>> sv/coil_ram.sv
module coil_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read-before-write on a same-address collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/coil_ctrl.sv
module coil_ctrl
  import coil_pkg::*;
#(
  parameter int DEPTH     = 16,
  parameter int ITEM_BITS = 8,
  parameter int IW        = $clog2(DEPTH),
  parameter int CW        = $clog2(DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  mode_e                in_mode_i,
  input  logic [ITEM_BITS-1:0] in_item_i,
  output rsp_t                 rsp_o,
  output logic [CW-1:0]        rsp_count_o,
  input  logic                 rsp_ready_i,
  output logic                 ram_we_o,
  output logic [IW-1:0]        ram_waddr_o,
  output logic [ITEM_BITS-1:0] ram_wdata_o,
  output logic [IW-1:0]        ram_raddr_o,
  input  logic [ITEM_BITS-1:0] ram_rdata_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_ROT_WR, S_SRCH, S_SHIFT, S_RD_FRONT, S_RESP
  } state_e;

  state_e               state_q, state_d;
  mode_e                mode_q, mode_d;
  logic [ITEM_BITS-1:0] item_q, item_d;
  logic [IW-1:0]        front_q, front_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        rd_q, rd_d;
  logic [CW-1:0]        wr_q, wr_d;
  logic                 vld_q, vld_d;
  status_e              status_q, status_d;
  logic                 full;

  // physical slot of list position pos
  function automatic logic [IW-1:0] slot(input logic [IW-1:0] f, input logic [CW-1:0] pos);
    logic [CW:0] s;
    s = (CW+1)'(f) + (CW+1)'(pos);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[IW-1:0];
  endfunction

  assign full = (count_q == CW'(DEPTH));

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    item_d      = item_q;
    front_d     = front_q;
    count_d     = count_q;
    rd_d        = rd_q;
    wr_d        = wr_q;
    vld_d       = vld_q;
    status_d    = status_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = front_q;
    ram_wdata_o = item_q;
    ram_raddr_o = front_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mode_d  = in_mode_i;
          item_d  = in_item_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        status_d = ST_DONE;
        state_d  = S_RD_FRONT;
        unique case (mode_q)
          MODE_INS_FRONT: begin
            if (full) begin
              status_d = ST_FULL;
            end else begin
              front_d     = (front_q == '0) ? IW'(DEPTH - 1) : front_q - IW'(1);
              ram_we_o    = 1'b1;
              ram_waddr_o = front_d;
              count_d     = count_q + CW'(1);
            end
          end
          MODE_INS_BACK: begin
            if (full) begin
              status_d = ST_FULL;
            end else begin
              ram_we_o    = 1'b1;
              ram_waddr_o = slot(front_q, count_q);
              count_d     = count_q + CW'(1);
            end
          end
          MODE_REMOVE: begin
            if (count_q == '0) begin
              status_d = ST_EMPTY;
            end else begin
              rd_d    = '0;
              vld_d   = 1'b0;
              state_d = S_SRCH;
            end
          end
          MODE_ROTATE: begin
            // front entry is read here, copied to the back next cycle
            if (count_q == '0) begin
              status_d = ST_EMPTY;
            end else if (count_q != CW'(1)) begin
              state_d = S_ROT_WR;
            end
          end
          default: ;
        endcase
      end
      S_ROT_WR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = slot(front_q, count_q);
        ram_wdata_o = ram_rdata_i;
        front_d     = (front_q == IW'(DEPTH - 1)) ? '0 : front_q + IW'(1);
        state_d     = S_RD_FRONT;
      end
      S_SRCH: begin
        // wr_q holds the position whose data is on the read port
        if (vld_q && ram_rdata_i == item_q) begin
          rd_d    = wr_q + CW'(1);
          vld_d   = 1'b0;
          state_d = S_SHIFT;
        end else if (vld_q && wr_q == count_q - CW'(1)) begin
          status_d = ST_NOMATCH;
          state_d  = S_RD_FRONT;
        end else if (rd_q < count_q) begin
          ram_raddr_o = slot(front_q, rd_q);
          rd_d        = rd_q + CW'(1);
          wr_d        = rd_q;
          vld_d       = 1'b1;
        end else begin
          vld_d = 1'b0;
        end
      end
      S_SHIFT: begin
        // read position rd_q while writing the word read last cycle one place closer to the front
        vld_d = 1'b0;
        if (vld_q) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = slot(front_q, wr_q);
          ram_wdata_o = ram_rdata_i;
          wr_d        = wr_q + CW'(1);
        end
        if (rd_q < count_q) begin
          ram_raddr_o = slot(front_q, rd_q);
          rd_d        = rd_q + CW'(1);
          vld_d       = 1'b1;
        end else if (!vld_q) begin
          count_d = count_q - CW'(1);
          if (count_q == CW'(1)) begin
            front_d = '0;
          end
          state_d = S_RD_FRONT;
        end
      end
      S_RD_FRONT: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        if (rsp_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      front_q  <= '0;
      count_q  <= '0;
      vld_q    <= 1'b0;
      mode_q   <= MODE_INS_FRONT;
      status_q <= ST_DONE;
    end else begin
      state_q  <= state_d;
      front_q  <= front_d;
      count_q  <= count_d;
      vld_q    <= vld_d;
      mode_q   <= mode_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    rd_q   <= rd_d;
    wr_q   <= wr_d;
  end

  assign in_ready_o          = (state_q == S_IDLE);
  assign rsp_o.valid         = (state_q == S_RESP);
  assign rsp_o.status        = status_q;
  assign rsp_o.is_empty      = (count_q == '0);
  assign rsp_o.front_item    = (count_q == '0) ? '0 : FRONT_BITS'(ram_rdata_i);
  assign rsp_count_o         = count_q;

endmodule
